FILE: hdl/buddy_tree_allocator_core_macros.svh
// assertion macros for the buddy tree allocator
`ifndef BUDDY_TREE_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_TREE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define BTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/btalloc_pkg.sv
// shared types and constants of the buddy tree allocator
package btalloc_pkg;

    localparam int MAX_LEVELS_DEF = 11;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_RESERVE = 2'd3;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam int LOG_VAL_W = 41;
    localparam int LOG_RES_W = 6;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_BAD     = 2'd2,
        ST_CONFIG  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SPAN,
        S_CLEAR,
        S_HEAD_START,
        S_HEAD_LOG,
        S_TAIL_START,
        S_TAIL_LOG,
        S_MARK,
        S_ALLOC_LOG,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIT_BUD_RD,
        S_FIT_BUD_CHK,
        S_FIT_PAR_RD,
        S_FIT_PAR_CHK,
        S_FREE_PREP,
        S_FREE_RANGE,
        S_FREE_RD,
        S_FREE_CHK,
        S_KID0_RD,
        S_KID0_CHK,
        S_KID1_RD,
        S_KID1_CHK,
        S_ALIGN,
        S_CLR_WR,
        S_UP_RD,
        S_UP_CHK,
        S_FREE_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [39:0] request_bytes;
        logic [63:0] free_address;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] block_address;
        logic [40:0] block_bytes;
        logic [40:0] reserved_total;
    } result_t;

    typedef struct packed {
        logic                 start;
        logic [LOG_VAL_W-1:0] value;
    } log_req_t;

    typedef struct packed {
        logic                 done;
        logic [LOG_RES_W-1:0] result;
    } log_rsp_t;

endpackage

FILE: hdl/btalloc_log2_unit.sv
// iterative ceiling log2, one candidate exponent per cycle
module btalloc_log2_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  btalloc_pkg::log_req_t req,
    output btalloc_pkg::log_rsp_t rsp
);

    logic                                busy_reg;
    logic                                busy_next;
    logic [btalloc_pkg::LOG_RES_W-1:0]   r_reg;
    logic [btalloc_pkg::LOG_RES_W-1:0]   r_next;
    logic [btalloc_pkg::LOG_VAL_W-1:0]   x_reg;
    logic [btalloc_pkg::LOG_VAL_W-1:0]   x_next;
    logic                                less;

    // power of two still below the value: keep climbing
    assign less = ((btalloc_pkg::LOG_VAL_W+1)'(1) << r_reg) < {1'b0, x_reg};

    always_comb
    begin
        busy_next = busy_reg;
        r_next    = r_reg;
        x_next    = x_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            r_next    = '0;
            x_next    = req.value;
        end
        else if (busy_reg)
        begin
            if (less)
            begin
                r_next = r_reg + 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        x_reg <= x_next;
    end

    assign rsp.done   = busy_reg && !less;
    assign rsp.result = r_reg;

endmodule

FILE: hdl/btalloc_mark_ram.sv
// one-bit node mark memory, single port, registered read
module btalloc_mark_ram
#(
    parameter int ADDR_W = btalloc_pkg::MAX_LEVELS_DEF,
    parameter int DEPTH  = (1 << btalloc_pkg::MAX_LEVELS_DEF) - 1
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic              wdata,
    output logic              rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/buddy_tree_allocator_core.sv
// buddy tree allocator top level: sequencer around a node mark memory
// init: a clear sweep over every node mark plus up to three log2 runs (size, head, tail)
// allocate: log2 run, then a read and a check per marked candidate, plus a climb on a free one
// free: range checks, a search up the tree, child checks, then a clearing climb; one mark port
// one item at a time; next command taken the cycle after the one-cycle result strobe
// reset clears control and configuration; marks are unknown until the first init sweep
module buddy_tree_allocator_core
#(
    parameter int MAX_LEVELS = btalloc_pkg::MAX_LEVELS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // command transfer
    input  logic                                  start,
    output logic                                  busy,
    input  btalloc_pkg::cmd_t                     cmd,
    // result transfer
    output logic                                  done,
    output btalloc_pkg::result_t                  result,
    // configuration write transfer
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [btalloc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                           cfg_data
);

`include "buddy_tree_allocator_core_macros.svh"

    // tree geometry
    localparam int IDX_W = MAX_LEVELS;
    localparam int OFF_W = MAX_LEVELS - 1;
    localparam int LVL_W = $clog2(MAX_LEVELS);
    localparam int NODES = (1 << MAX_LEVELS) - 1;

    // node (level, offset) lives at 2^level - 1 + offset in heap order
    function automatic logic [IDX_W-1:0] node_idx(input logic [LVL_W-1:0] lvl,
                                                  input logic [OFF_W-1:0] off);
        logic [IDX_W-1:0] first;
        first = (IDX_W'(1) << lvl) - IDX_W'(1);
        return first + IDX_W'(off);
    endfunction

    // last offset of a level
    function automatic logic [OFF_W-1:0] level_last(input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] span;
        span = (IDX_W'(1) << lvl) - IDX_W'(1);
        return OFF_W'(span);
    endfunction

    // configuration registers
    logic [63:0] base_cfg_reg;
    logic [39:0] mem_bytes_reg;
    logic [4:0]  page_shift_reg;
    logic [39:0] head_reg;

    // tree state
    btalloc_pkg::state_t state_reg, state_next;
    logic             ready_reg,     ready_next;
    logic [5:0]       span_reg,      span_next;
    logic [LVL_W-1:0] depth_reg,     depth_next;
    logic [4:0]       pg_reg,        pg_next;
    logic [63:0]      tree_base_reg, tree_base_next;
    logic [40:0]      reserved_reg,  reserved_next;

    // working registers
    logic [1:0]       op_reg,        op_next;
    logic [63:0]      addr_reg,      addr_next;
    logic [63:0]      d_reg,         d_next;
    logic [LVL_W-1:0] lvl_reg,       lvl_next;
    logic [OFF_W-1:0] off_reg,       off_next;
    logic [LVL_W-1:0] cand_lvl_reg,  cand_lvl_next;
    logic [OFF_W-1:0] cand_reg,      cand_next;
    logic [5:0]       shift_reg,     shift_next;
    logic             tail_phase_reg, tail_phase_next;
    logic [IDX_W-1:0] clr_idx_reg,   clr_idx_next;

    // result registers
    btalloc_pkg::status_t res_status_reg, res_status_next;
    logic [63:0]      res_addr_reg,  res_addr_next;
    logic [40:0]      res_bytes_reg, res_bytes_next;

    // memory and log2 unit hookup
    logic             ram_rd_en;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_addr;
    logic             ram_wdata;
    logic             rbit;
    btalloc_pkg::log_req_t log_req;
    btalloc_pkg::log_rsp_t log_rsp;

    // shared conditions
    logic             accept;
    logic [5:0]       sp_w;
    logic [5:0]       drw_w;
    logic             too_deep;
    logic [5:0]       c_eff;
    logic             c_big;
    logic [LVL_W-1:0] lvl_from_log;
    logic             lvl_zero;
    logic             cand_last;
    logic             clr_last;
    logic             head_zero;
    logic [40:0]      tail_diff;
    logic             tail_zero;
    logic             free_below;
    logic             out_range;
    logic [63:0]      align_exp;
    logic             misalign;
    logic [40:0]      blk;
    logic             alloc_ok;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // span of the region: max(ceil log2 bytes, page shift)
    assign sp_w     = (log_rsp.result > {1'b0, page_shift_reg}) ?
                      log_rsp.result : {1'b0, page_shift_reg};
    assign drw_w    = sp_w - {1'b0, page_shift_reg};
    assign too_deep = drw_w > 6'(MAX_LEVELS - 1);

    // level of a size: span minus ceil log2 of the size raised to one page
    assign c_eff        = (log_rsp.result > {1'b0, pg_reg}) ? log_rsp.result : {1'b0, pg_reg};
    assign c_big        = c_eff > span_reg;
    assign lvl_from_log = c_big ? '0 : LVL_W'(span_reg - c_eff);

    assign lvl_zero  = lvl_reg == '0;
    assign cand_last = cand_reg == level_last(cand_lvl_reg);
    assign clr_last  = clr_idx_reg == IDX_W'(NODES - 1);
    assign head_zero = head_reg == '0;
    assign tail_diff = (41'(1) << span_reg) - {1'b0, mem_bytes_reg};
    assign tail_zero = tail_diff == '0;

    assign free_below = addr_reg < tree_base_reg;
    assign out_range  = (d_reg >> span_reg) != '0;
    assign align_exp  = 64'(off_reg) << (span_reg - 6'(lvl_reg));
    assign misalign   = d_reg != align_exp;
    assign blk        = 41'(1) << shift_reg;

    btalloc_mark_ram
    #(
        .ADDR_W (IDX_W),
        .DEPTH  (NODES)
    )
    u_mark_ram
    (
        .clk   (clk),
        .rd_en (ram_rd_en),
        .wr_en (ram_wr_en),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rbit)
    );

    btalloc_log2_unit u_log2
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btalloc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        btalloc_pkg::OP_INIT:  state_next = btalloc_pkg::S_SPAN;
                        btalloc_pkg::OP_ALLOC: state_next = ready_reg ?
                                               btalloc_pkg::S_ALLOC_LOG : btalloc_pkg::S_DONE;
                        btalloc_pkg::OP_FREE:  state_next = ready_reg ?
                                               btalloc_pkg::S_FREE_PREP : btalloc_pkg::S_DONE;
                        default:               state_next = btalloc_pkg::S_DONE;
                    endcase
                end
            end
            btalloc_pkg::S_SPAN:
            begin
                if (log_rsp.done)
                begin
                    state_next = too_deep ? btalloc_pkg::S_DONE : btalloc_pkg::S_CLEAR;
                end
            end
            btalloc_pkg::S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = btalloc_pkg::S_HEAD_START;
                end
            end
            btalloc_pkg::S_HEAD_START:
            begin
                state_next = head_zero ? btalloc_pkg::S_TAIL_START : btalloc_pkg::S_HEAD_LOG;
            end
            btalloc_pkg::S_HEAD_LOG:
            begin
                if (log_rsp.done)
                begin
                    state_next = btalloc_pkg::S_MARK;
                end
            end
            btalloc_pkg::S_TAIL_START:
            begin
                state_next = tail_zero ? btalloc_pkg::S_DONE : btalloc_pkg::S_TAIL_LOG;
            end
            btalloc_pkg::S_TAIL_LOG:
            begin
                if (log_rsp.done)
                begin
                    state_next = btalloc_pkg::S_MARK;
                end
            end
            btalloc_pkg::S_MARK:
            begin
                if (lvl_zero)
                begin
                    if (op_reg == btalloc_pkg::OP_INIT && !tail_phase_reg)
                    begin
                        state_next = btalloc_pkg::S_TAIL_START;
                    end
                    else
                    begin
                        state_next = btalloc_pkg::S_DONE;
                    end
                end
            end
            btalloc_pkg::S_ALLOC_LOG:
            begin
                if (log_rsp.done)
                begin
                    state_next = c_big ? btalloc_pkg::S_DONE : btalloc_pkg::S_SCAN_RD;
                end
            end
            btalloc_pkg::S_SCAN_RD:
            begin
                state_next = btalloc_pkg::S_SCAN_CHK;
            end
            btalloc_pkg::S_SCAN_CHK:
            begin
                if (rbit)
                begin
                    state_next = cand_last ? btalloc_pkg::S_DONE : btalloc_pkg::S_SCAN_RD;
                end
                else
                begin
                    state_next = btalloc_pkg::S_FIT_BUD_RD;
                end
            end
            btalloc_pkg::S_FIT_BUD_RD:
            begin
                state_next = lvl_zero ? btalloc_pkg::S_MARK : btalloc_pkg::S_FIT_BUD_CHK;
            end
            btalloc_pkg::S_FIT_BUD_CHK:
            begin
                state_next = rbit ? btalloc_pkg::S_MARK : btalloc_pkg::S_FIT_PAR_RD;
            end
            btalloc_pkg::S_FIT_PAR_RD:
            begin
                state_next = btalloc_pkg::S_FIT_PAR_CHK;
            end
            btalloc_pkg::S_FIT_PAR_CHK:
            begin
                if (rbit)
                begin
                    state_next = cand_last ? btalloc_pkg::S_DONE : btalloc_pkg::S_SCAN_RD;
                end
                else
                begin
                    state_next = btalloc_pkg::S_FIT_BUD_RD;
                end
            end
            btalloc_pkg::S_FREE_PREP:
            begin
                state_next = free_below ? btalloc_pkg::S_DONE : btalloc_pkg::S_FREE_RANGE;
            end
            btalloc_pkg::S_FREE_RANGE:
            begin
                state_next = out_range ? btalloc_pkg::S_DONE : btalloc_pkg::S_FREE_RD;
            end
            btalloc_pkg::S_FREE_RD:
            begin
                state_next = btalloc_pkg::S_FREE_CHK;
            end
            btalloc_pkg::S_FREE_CHK:
            begin
                if (rbit)
                begin
                    state_next = (lvl_reg < depth_reg) ?
                                 btalloc_pkg::S_KID0_RD : btalloc_pkg::S_ALIGN;
                end
                else
                begin
                    state_next = lvl_zero ? btalloc_pkg::S_DONE : btalloc_pkg::S_FREE_RD;
                end
            end
            btalloc_pkg::S_KID0_RD:
            begin
                state_next = btalloc_pkg::S_KID0_CHK;
            end
            btalloc_pkg::S_KID0_CHK:
            begin
                state_next = rbit ? btalloc_pkg::S_DONE : btalloc_pkg::S_KID1_RD;
            end
            btalloc_pkg::S_KID1_RD:
            begin
                state_next = btalloc_pkg::S_KID1_CHK;
            end
            btalloc_pkg::S_KID1_CHK:
            begin
                state_next = rbit ? btalloc_pkg::S_DONE : btalloc_pkg::S_ALIGN;
            end
            btalloc_pkg::S_ALIGN:
            begin
                state_next = misalign ? btalloc_pkg::S_DONE : btalloc_pkg::S_CLR_WR;
            end
            btalloc_pkg::S_CLR_WR:
            begin
                state_next = btalloc_pkg::S_UP_RD;
            end
            btalloc_pkg::S_UP_RD:
            begin
                state_next = lvl_zero ? btalloc_pkg::S_FREE_FIN : btalloc_pkg::S_UP_CHK;
            end
            btalloc_pkg::S_UP_CHK:
            begin
                state_next = rbit ? btalloc_pkg::S_FREE_FIN : btalloc_pkg::S_CLR_WR;
            end
            btalloc_pkg::S_FREE_FIN:
            begin
                state_next = btalloc_pkg::S_DONE;
            end
            btalloc_pkg::S_DONE:
            begin
                state_next = btalloc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = btalloc_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory access and log2 requests per state
    always_comb
    begin
        ready_next      = ready_reg;
        span_next       = span_reg;
        depth_next      = depth_reg;
        pg_next         = pg_reg;
        tree_base_next  = tree_base_reg;
        reserved_next   = reserved_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        d_next          = d_reg;
        lvl_next        = lvl_reg;
        off_next        = off_reg;
        cand_lvl_next   = cand_lvl_reg;
        cand_next       = cand_reg;
        shift_next      = shift_reg;
        tail_phase_next = tail_phase_reg;
        clr_idx_next    = clr_idx_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_bytes_next  = res_bytes_reg;
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;
        ram_addr        = node_idx(lvl_reg, off_reg);
        ram_wdata       = 1'b0;
        log_req.start   = 1'b0;
        log_req.value   = '0;
        case (state_reg)
            btalloc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = cmd.operation;
                    addr_next       = cmd.free_address;
                    res_status_next = btalloc_pkg::ST_OK;
                    res_addr_next   = '0;
                    res_bytes_next  = '0;
                    tail_phase_next = 1'b0;
                    case (cmd.operation)
                        btalloc_pkg::OP_INIT:
                        begin
                            log_req.start = 1'b1;
                            log_req.value = {1'b0, mem_bytes_reg};
                        end
                        btalloc_pkg::OP_ALLOC:
                        begin
                            if (ready_reg)
                            begin
                                log_req.start = 1'b1;
                                log_req.value = {1'b0, cmd.request_bytes};
                            end
                            else
                            begin
                                res_status_next = btalloc_pkg::ST_CONFIG;
                            end
                        end
                        btalloc_pkg::OP_FREE:
                        begin
                            if (!ready_reg)
                            begin
                                res_status_next = btalloc_pkg::ST_CONFIG;
                            end
                        end
                        default:
                        begin
                            res_status_next = btalloc_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            btalloc_pkg::S_SPAN:
            begin
                if (log_rsp.done)
                begin
                    reserved_next = '0;
                    if (too_deep)
                    begin
                        res_status_next = btalloc_pkg::ST_CONFIG;
                        ready_next      = 1'b0;
                        span_next       = '0;
                        depth_next      = '0;
                    end
                    else
                    begin
                        ready_next     = 1'b1;
                        span_next      = sp_w;
                        depth_next     = LVL_W'(drw_w);
                        pg_next        = page_shift_reg;
                        tree_base_next = base_cfg_reg;
                        clr_idx_next   = '0;
                    end
                end
            end
            btalloc_pkg::S_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_addr     = clr_idx_reg;
                ram_wdata    = 1'b0;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            btalloc_pkg::S_HEAD_START:
            begin
                if (!head_zero)
                begin
                    log_req.start = 1'b1;
                    log_req.value = {1'b0, head_reg};
                end
            end
            btalloc_pkg::S_HEAD_LOG:
            begin
                if (log_rsp.done)
                begin
                    lvl_next = lvl_from_log;
                    off_next = '0;
                end
            end
            btalloc_pkg::S_TAIL_START:
            begin
                if (!tail_zero)
                begin
                    log_req.start = 1'b1;
                    log_req.value = tail_diff;
                end
            end
            btalloc_pkg::S_TAIL_LOG:
            begin
                if (log_rsp.done)
                begin
                    lvl_next        = lvl_from_log;
                    off_next        = level_last(lvl_from_log);
                    tail_phase_next = 1'b1;
                end
            end
            btalloc_pkg::S_MARK:
            begin
                // set the node and every ancestor up to the root
                ram_wr_en = 1'b1;
                ram_wdata = 1'b1;
                if (!lvl_zero)
                begin
                    lvl_next = lvl_reg - 1'b1;
                    off_next = off_reg >> 1;
                end
                else if (op_reg == btalloc_pkg::OP_ALLOC)
                begin
                    reserved_next  = reserved_reg + blk;
                    res_addr_next  = tree_base_reg + (64'(cand_reg) << shift_reg);
                    res_bytes_next = blk;
                end
            end
            btalloc_pkg::S_ALLOC_LOG:
            begin
                if (log_rsp.done)
                begin
                    if (c_big)
                    begin
                        res_status_next = btalloc_pkg::ST_BAD;
                    end
                    else
                    begin
                        cand_lvl_next = lvl_from_log;
                        shift_next    = c_eff;
                        cand_next     = '0;
                    end
                end
            end
            btalloc_pkg::S_SCAN_RD:
            begin
                ram_rd_en = 1'b1;
                ram_addr  = node_idx(cand_lvl_reg, cand_reg);
                lvl_next  = cand_lvl_reg;
                off_next  = cand_reg;
            end
            btalloc_pkg::S_SCAN_CHK,
            btalloc_pkg::S_FIT_PAR_CHK:
            begin
                // marked candidate or allocated ancestor: move to the next offset, or report no free block
                if (rbit)
                begin
                    if (cand_last)
                    begin
                        res_status_next = btalloc_pkg::ST_NO_FREE;
                    end
                    else
                    begin
                        cand_next = cand_reg + 1'b1;
                    end
                end
            end
            btalloc_pkg::S_FIT_BUD_RD:
            begin
                if (lvl_zero)
                begin
                    lvl_next = cand_lvl_reg;
                    off_next = cand_reg;
                end
                else
                begin
                    ram_rd_en = 1'b1;
                    ram_addr  = node_idx(lvl_reg, off_reg ^ OFF_W'(1));
                end
            end
            btalloc_pkg::S_FIT_BUD_CHK:
            begin
                if (rbit)
                begin
                    lvl_next = cand_lvl_reg;
                    off_next = cand_reg;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                    off_next = off_reg >> 1;
                end
            end
            btalloc_pkg::S_FIT_PAR_RD:
            begin
                ram_rd_en = 1'b1;
            end
            btalloc_pkg::S_FREE_PREP:
            begin
                res_status_next = btalloc_pkg::ST_BAD;
                d_next          = addr_reg - tree_base_reg;
            end
            btalloc_pkg::S_FREE_RANGE:
            begin
                if (!out_range)
                begin
                    lvl_next = depth_reg;
                    off_next = OFF_W'(d_reg >> pg_reg);
                end
            end
            btalloc_pkg::S_FREE_RD:
            begin
                ram_rd_en = 1'b1;
            end
            btalloc_pkg::S_FREE_CHK:
            begin
                if (!rbit && !lvl_zero)
                begin
                    lvl_next = lvl_reg - 1'b1;
                    off_next = off_reg >> 1;
                end
            end
            btalloc_pkg::S_KID0_RD:
            begin
                ram_rd_en = 1'b1;
                ram_addr  = node_idx(LVL_W'(lvl_reg + 1'b1), OFF_W'({off_reg, 1'b0}));
            end
            btalloc_pkg::S_KID1_RD:
            begin
                ram_rd_en = 1'b1;
                ram_addr  = node_idx(LVL_W'(lvl_reg + 1'b1), OFF_W'({off_reg, 1'b1}));
            end
            btalloc_pkg::S_ALIGN:
            begin
                shift_next = span_reg - 6'(lvl_reg);
            end
            btalloc_pkg::S_CLR_WR:
            begin
                ram_wr_en = 1'b1;
                ram_wdata = 1'b0;
            end
            btalloc_pkg::S_UP_RD:
            begin
                if (!lvl_zero)
                begin
                    ram_rd_en = 1'b1;
                    ram_addr  = node_idx(lvl_reg, off_reg ^ OFF_W'(1));
                end
            end
            btalloc_pkg::S_UP_CHK:
            begin
                if (!rbit)
                begin
                    lvl_next = lvl_reg - 1'b1;
                    off_next = off_reg >> 1;
                end
            end
            btalloc_pkg::S_FREE_FIN:
            begin
                // count saturates at zero when a reserve block is released
                reserved_next   = (reserved_reg >= blk) ? (reserved_reg - blk) : '0;
                res_bytes_next  = blk;
                res_status_next = btalloc_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= btalloc_pkg::S_IDLE;
            ready_reg      <= 1'b0;
            span_reg       <= '0;
            depth_reg      <= '0;
            pg_reg         <= '0;
            tree_base_reg  <= '0;
            reserved_reg   <= '0;
            base_cfg_reg   <= '0;
            mem_bytes_reg  <= '0;
            page_shift_reg <= 5'd12;
            head_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            span_reg      <= span_next;
            depth_reg     <= depth_next;
            pg_reg        <= pg_next;
            tree_base_reg <= tree_base_next;
            reserved_reg  <= reserved_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    btalloc_pkg::CFG_BASE_ADDRESS: base_cfg_reg   <= cfg_data;
                    btalloc_pkg::CFG_MEMORY_BYTES: mem_bytes_reg  <= cfg_data[39:0];
                    btalloc_pkg::CFG_PAGE_SHIFT:   page_shift_reg <= cfg_data[4:0];
                    btalloc_pkg::CFG_HEAD_RESERVE: head_reg       <= cfg_data[39:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        d_reg          <= d_next;
        lvl_reg        <= lvl_next;
        off_reg        <= off_next;
        cand_lvl_reg   <= cand_lvl_next;
        cand_reg       <= cand_next;
        shift_reg      <= shift_next;
        tail_phase_reg <= tail_phase_next;
        clr_idx_reg    <= clr_idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_bytes_reg  <= res_bytes_next;
    end

    // result for one cycle in the done state
    assign busy                  = state_reg != btalloc_pkg::S_IDLE;
    assign done                  = state_reg == btalloc_pkg::S_DONE;
    assign result.status         = res_status_reg;
    assign result.block_address  = res_addr_reg;
    assign result.block_bytes    = res_bytes_reg;
    assign result.reserved_total = reserved_reg;

    // good allocation result on the strobe
    assign alloc_ok = done && op_reg == btalloc_pkg::OP_ALLOC &&
                      result.status == btalloc_pkg::ST_OK;

    // a command transfer always makes the sequencer busy
    `BTA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command left block idle")
    // one memory port: never read and write in the same cycle
    `BTA_ASSERT_NOW(a_ram_port, ram_rd_en, !ram_wr_en, "mark memory read and write collide")
    // result strobe is a single cycle
    `BTA_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    // a good allocation always hands out a nonempty block
    `BTA_ASSERT_NOW(a_alloc_size, alloc_ok, result.block_bytes != '0, "allocation returned empty block")

endmodule
